@@ hw/rtl/dcp_pkg.sv @@
// ----------------------------------------------------------------------------
// dcp_pkg: shared types and constants for the depth-to-color projection core
// Holds the payload structs, the register map, the configuration bundle and
// the datapath widths shared by the front, queue and back modules.
// ----------------------------------------------------------------------------
package dcp_pkg;

  // Depth frame size and coefficient format.
  localparam int unsigned DepthWidth   = 512;
  localparam int unsigned DepthHeight  = 424;
  localparam int unsigned CoefFracBits = 16;

  // Invalid depth codes.
  localparam logic [15:0] DEPTH_NONE = 16'h0000;
  localparam logic [15:0] DEPTH_SAT  = 16'hFFFF;

  // Register map.
  localparam logic [2:0] REG_M00_M01 = 3'd0;
  localparam logic [2:0] REG_M02_M10 = 3'd1;
  localparam logic [2:0] REG_M11_M12 = 3'd2;
  localparam logic [2:0] REG_M20_M21 = 3'd3;
  localparam logic [2:0] REG_M22_T0  = 3'd4;
  localparam logic [2:0] REG_T1_T2   = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_HEIGHT  = 3'd7;

  localparam logic [12:0] WIDTH_RESET  = 13'd1920;
  localparam logic [12:0] HEIGHT_RESET = 13'd1080;

  // Width of the projected numerators d*(M*uv)+T.
  localparam int unsigned NumW = 60;
  // Width of a magnitude or of a positive denominator.
  localparam int unsigned MagW = NumW - 1;
  // Quotient bits kept; a quotient at or above 2**QuotW is off frame.
  localparam int unsigned QuotW = 12;

  typedef struct packed {
    logic [15:0] depth_mm;
    logic [8:0]  pixel_col;
    logic [8:0]  pixel_row;
  } in_t;

  typedef struct packed {
    logic [11:0] color_x;
    logic [11:0] color_y;
    logic        hit;
  } out_t;

  typedef struct packed {
    logic [5:0][63:0] coef;
    logic [12:0]      width;
    logic [12:0]      height;
  } cfg_t;

  // One entry of the queue between front and back.
  typedef struct packed {
    logic                   ok;
    logic signed [NumW-1:0] nx;
    logic signed [NumW-1:0] ny;
    logic signed [NumW-1:0] nz;
  } proj_t;

endpackage

@@ hw/rtl/depth_to_color_projection_core.sv @@
// ----------------------------------------------------------------------------
// depth_to_color_projection_core: depth pixel to color frame registration
// Projects each depth pixel through a configured matrix and translation and
// divides by z to find its color-frame position.
//
//   channel  | ports                            | moves
//   ---------+----------------------------------+-------------------------
//   input    | push, full, in_data_i            | one depth pixel
//   result   | pop, empty, out_data_o           | one color position + hit
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i  | one register write
//
// One pixel is accepted per cycle while full is low. A result passes through
// four front stages, the queue, and the divider, which resolves one quotient
// bit per stage, before it is shown. Reset clears all valid state and loads
// the register defaults. A stalled result stops the back; the two-entry queue
// lets the front run on until it fills, then full rises.
// ----------------------------------------------------------------------------
module depth_to_color_projection_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  input  logic          push,
  output logic          full,
  input  dcp_pkg::in_t  in_data_i,
  output logic          empty,
  input  logic          pop,
  output dcp_pkg::out_t out_data_o
);

  dcp_pkg::cfg_t  cfg;
  dcp_pkg::proj_t f_data, q_data;
  logic           f_valid, f_adv;
  logic           q_full, q_empty, q_pop, b_adv;

  dcp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The front moves whenever the queue can take its last stage.
  assign f_adv = !q_full || q_pop;
  assign full  = !f_adv;
  assign q_pop = b_adv && !q_empty;

  dcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (push && f_adv),
    .in_data_i   (in_data_i),
    .adv_i       (f_adv),
    .out_valid_o (f_valid),
    .out_data_o  (f_data)
  );

  dcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid && f_adv),
    .data_i  (f_data),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  dcp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (!q_empty),
    .in_data_i  (q_data),
    .adv_o      (b_adv),
    .empty_o    (empty),
    .data_o     (out_data_o),
    .pop_i      (pop)
  );

endmodule

@@ hw/rtl/dcp_cfg.sv @@
// ----------------------------------------------------------------------------
// dcp_cfg: configuration register file
// Write-only registers for the coefficients and the color frame size.
// ----------------------------------------------------------------------------
module dcp_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  output dcp_pkg::cfg_t cfg_o
);

  dcp_pkg::cfg_t cfg_d, cfg_q;

  // Decode the register index.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        dcp_pkg::REG_M00_M01: cfg_d.coef[0] = cfg_data_i;
        dcp_pkg::REG_M02_M10: cfg_d.coef[1] = cfg_data_i;
        dcp_pkg::REG_M11_M12: cfg_d.coef[2] = cfg_data_i;
        dcp_pkg::REG_M20_M21: cfg_d.coef[3] = cfg_data_i;
        dcp_pkg::REG_M22_T0:  cfg_d.coef[4] = cfg_data_i;
        dcp_pkg::REG_T1_T2:   cfg_d.coef[5] = cfg_data_i;
        dcp_pkg::REG_WIDTH:   cfg_d.width  = cfg_data_i[12:0];
        dcp_pkg::REG_HEIGHT:  cfg_d.height = cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef   <= '0;
      cfg_q.width  <= dcp_pkg::WIDTH_RESET;
      cfg_q.height <= dcp_pkg::HEIGHT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/dcp_front.sv @@
// ----------------------------------------------------------------------------
// dcp_front: pixel classification and projection numerators
// Four-stage pipeline: products, row sums, depth scaling, translation.
// ----------------------------------------------------------------------------
module dcp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dcp_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  input  dcp_pkg::in_t   in_data_i,
  input  logic           adv_i,
  output logic           out_valid_o,
  output dcp_pkg::proj_t out_data_o
);

  localparam int unsigned NumW = dcp_pkg::NumW;

  logic signed [31:0] m [9];
  logic signed [31:0] t [3];
  logic               in_ok;

  logic [3:0]         v_q;
  logic               ok1_q, ok2_q, ok3_q;
  logic [15:0]        d1_q, d2_q;
  logic signed [41:0] pc_q [3];
  logic signed [41:0] pr_q [3];
  logic signed [31:0] pk_q [3];
  logic signed [42:0] s_q [3];
  logic signed [NumW-1:0] n_q [3];
  dcp_pkg::proj_t     o_q;

  // Unpack the coefficient words.
  always_comb begin
    m[0] = cfg_i.coef[0][63:32];
    m[1] = cfg_i.coef[0][31:0];
    m[2] = cfg_i.coef[1][63:32];
    m[3] = cfg_i.coef[1][31:0];
    m[4] = cfg_i.coef[2][63:32];
    m[5] = cfg_i.coef[2][31:0];
    m[6] = cfg_i.coef[3][63:32];
    m[7] = cfg_i.coef[3][31:0];
    m[8] = cfg_i.coef[4][63:32];
    t[0] = cfg_i.coef[4][31:0];
    t[1] = cfg_i.coef[5][63:32];
    t[2] = cfg_i.coef[5][31:0];
  end

  // Valid depth and a pixel inside the depth frame.
  assign in_ok = (in_data_i.depth_mm != dcp_pkg::DEPTH_NONE)
              && (in_data_i.depth_mm != dcp_pkg::DEPTH_SAT)
              && ({23'd0, in_data_i.pixel_col} < dcp_pkg::DepthWidth)
              && ({23'd0, in_data_i.pixel_row} < dcp_pkg::DepthHeight);

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  // Datapath stages.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ok1_q <= in_ok;
      d1_q  <= in_data_i.depth_mm;
      for (int k = 0; k < 3; k++) begin
        pc_q[k] <= m[3*k]   * $signed({1'b0, in_data_i.pixel_col});
        pr_q[k] <= m[3*k+1] * $signed({1'b0, in_data_i.pixel_row});
        pk_q[k] <= m[3*k+2];
      end
      ok2_q <= ok1_q;
      d2_q  <= d1_q;
      for (int k = 0; k < 3; k++) begin
        s_q[k] <= pc_q[k] + pr_q[k] + pk_q[k];
      end
      ok3_q <= ok2_q;
      for (int k = 0; k < 3; k++) begin
        n_q[k] <= s_q[k] * $signed({1'b0, d2_q});
      end
      o_q.ok <= ok3_q;
      o_q.nx <= n_q[0] + t[0];
      o_q.ny <= n_q[1] + t[1];
      o_q.nz <= n_q[2] + t[2];
    end
  end

  assign out_valid_o = v_q[3];
  assign out_data_o  = o_q;

endmodule

@@ hw/rtl/dcp_queue.sv @@
// ----------------------------------------------------------------------------
// dcp_queue: two-entry queue between front and back
// Lets the front keep running while the back is stalled for one or two items.
// ----------------------------------------------------------------------------
module dcp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dcp_pkg::proj_t data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output dcp_pkg::proj_t data_o
);

  dcp_pkg::proj_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // Occupancy update.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/dcp_back.sv @@
// ----------------------------------------------------------------------------
// dcp_back: perspective divide and frame test
// Sign handling, a pipelined restoring divider (one quotient bit per stage,
// x and y side by side) and the output register.
// ----------------------------------------------------------------------------
module dcp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dcp_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  input  dcp_pkg::proj_t in_data_i,
  output logic           adv_o,
  output logic           empty_o,
  output dcp_pkg::out_t  data_o,
  input  logic           pop_i
);

  localparam int unsigned NumW   = dcp_pkg::NumW;
  localparam int unsigned MagW   = dcp_pkg::MagW;
  localparam int unsigned QuotW  = dcp_pkg::QuotW;
  localparam int unsigned Stages = QuotW + 2;
  localparam int unsigned WideW  = MagW + QuotW + 1;

  typedef struct packed {
    logic             ok;
    logic             negx;
    logic             negy;
    logic             ovx;
    logic             ovy;
    logic [MagW-1:0]  rx;
    logic [MagW-1:0]  ry;
    logic [MagW-1:0]  dv;
    logic [QuotW-1:0] qx;
    logic [QuotW-1:0] qy;
  } div_t;

  // One compare-subtract step for both quotients. The widest shift only
  // checks whether the quotient fits.
  function automatic div_t div_step(div_t s, int unsigned sh);
    div_t             r;
    logic [WideW-1:0] dsh;
    logic             gex, gey;
    r   = s;
    dsh = {{(WideW-MagW){1'b0}}, s.dv} << sh;
    gex = {{(WideW-MagW){1'b0}}, s.rx} >= dsh;
    gey = {{(WideW-MagW){1'b0}}, s.ry} >= dsh;
    if (sh == QuotW) begin
      r.ovx = gex;
      r.ovy = gey;
    end else begin
      if (gex) begin
        r.rx = s.rx - dsh[MagW-1:0];
        r.qx[sh[3:0]] = 1'b1;
      end
      if (gey) begin
        r.ry = s.ry - dsh[MagW-1:0];
        r.qy[sh[3:0]] = 1'b1;
      end
    end
    return r;
  endfunction

  logic [Stages-1:0]  v_q;
  div_t               st_q [Stages];
  div_t               st0_d;
  logic signed [NumW-1:0] negnx, negny;
  logic               out_v_q;
  dcp_pkg::out_t      out_q, out_d;
  div_t               last;
  logic               hit;

  assign adv_o   = !out_v_q || pop_i;
  assign empty_o = !out_v_q;
  assign data_o  = out_q;

  // Take magnitudes; a miss sets the divisor to one.
  always_comb begin
    negnx       = -in_data_i.nx;
    negny       = -in_data_i.ny;
    st0_d       = '0;
    st0_d.ok    = in_data_i.ok && !in_data_i.nz[NumW-1] && (in_data_i.nz != '0);
    st0_d.negx  = in_data_i.nx[NumW-1];
    st0_d.negy  = in_data_i.ny[NumW-1];
    st0_d.rx    = in_data_i.nx[NumW-1] ? negnx[MagW-1:0] : in_data_i.nx[MagW-1:0];
    st0_d.ry    = in_data_i.ny[NumW-1] ? negny[MagW-1:0] : in_data_i.ny[MagW-1:0];
    st0_d.dv    = st0_d.ok ? in_data_i.nz[MagW-1:0] : {{(MagW-1){1'b0}}, 1'b1};
  end

  // Final frame test. A negative numerator with a nonzero quotient lies left
  // of or above the frame; a zero quotient truncates to column or row zero.
  always_comb begin
    last = st_q[Stages-1];
    hit  = last.ok && !last.ovx && !last.ovy
        && !(last.negx && (last.qx != '0))
        && !(last.negy && (last.qy != '0))
        && ({1'b0, last.qx} < cfg_i.width)
        && ({1'b0, last.qy} < cfg_i.height);
    out_d.hit     = hit;
    out_d.color_x = hit ? last.qx : '0;
    out_d.color_y = hit ? last.qy : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (adv_o) begin
      v_q     <= {v_q[Stages-2:0], in_valid_i};
      out_v_q <= v_q[Stages-1];
    end
  end

  // Divider stages.
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      st_q[0] <= st0_d;
      for (int k = 1; k < Stages; k++) begin
        st_q[k] <= div_step(st_q[k-1], Stages - 1 - k);
      end
      out_q <= out_d;
    end
  end

endmodule
